// ----- rtl/hcbp_pkg.sv -----
// hcbp_pkg: shared types, widths and defaults of the huffman code bit packer
// no dependencies; imported by every module of the block
`default_nettype none

package hcbp_pkg;

  // fixed field widths
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;
  // working register: up to seven pending bits plus a full code word
  localparam int WORK_W  = CODE_W + BYTE_W;
  localparam int CNT_W   = 6;
  localparam int ENTRY_W = CODE_W + LEN_W;

  // parameter defaults
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  // action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMBINE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // request accepted: latch flags, read or write the table
    logic combine;     // merge pending bits with the looked-up code
    logic emit_full;   // send the top byte of the working register
    logic flush;       // send the zero-padded partial byte
    logic store_pend;  // keep leftover bits for the next request
    logic run_end;
    logic stream_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_ge8;
    logic cnt_eq8;
    logic cnt_lt16;
    logic cnt_zero;
    logic fin;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/hcbp_ctrl.sv -----
// hcbp_ctrl: sequencing state machine of the huffman code bit packer
// depends on hcbp_pkg; drives the datapath through cmd_t and reads sts_t
`default_nettype none

module hcbp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_action,
  output logic                in_ready,
  input  hcbp_pkg::sts_t      sts,
  output hcbp_pkg::cmd_t      cmd
);
  import hcbp_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == ACT_ENCODE) begin
            state_nxt = ST_COMBINE;
          end
        end
      end
      ST_COMBINE: begin
        cmd.combine = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        priority if (sts.cnt_ge8) begin
          // full byte; it is the last one when nothing more follows
          if (sts.out_free) begin
            cmd.emit_full  = 1'b1;
            cmd.run_end    = sts.cnt_lt16 && (sts.cnt_eq8 || !sts.fin);
            cmd.stream_end = sts.cnt_eq8 && sts.fin;
          end
        end else if (sts.fin && !sts.cnt_zero) begin
          // padded tail of the stream
          if (sts.out_free) begin
            cmd.flush      = 1'b1;
            cmd.run_end    = 1'b1;
            cmd.stream_end = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          cmd.store_pend = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/hcbp_datapath.sv -----
// hcbp_datapath: code table, bit accumulator and output register
// depends on hcbp_pkg; controlled by hcbp_ctrl through cmd_t
`default_nettype none

module hcbp_datapath #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_action,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    in_symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   in_code_word,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    in_code_length,
  input  wire logic                          in_final_symbol,
  input  hcbp_pkg::cmd_t                     cmd,
  output hcbp_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_run_end,
  output logic                               out_stream_end
);
  import hcbp_pkg::*;

  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [ENTRY_W-1:0] mem [SYMBOL_COUNT];
  logic [ENTRY_W-1:0] rd_r;
  logic               sym_ok_r;
  logic               fin_r;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [WORK_W-1:0]  work_r, work_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_run_end_r;
  logic               out_stream_end_r;

  logic               sym_ok;
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   len_clamp;
  logic [LEN_W-1:0]   len_eff;
  logic [CODE_W-1:0]  code_left;
  logic [BYTE_W-1:0]  pend_left;
  logic [BYTE_W-1:0]  tail_byte;

  // table address and range check
  assign sym_ok    = {1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx       = in_symbol[IDX_W-1:0];
  assign len_clamp = (in_code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : in_code_length;

  // code table: written on load, read on encode
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (in_action == ACT_LOAD && sym_ok) begin
        mem[idx] <= {len_clamp, in_code_word};
      end
      rd_r     <= mem[idx];
      sym_ok_r <= sym_ok;
      fin_r    <= in_final_symbol;
    end
  end

  // left-align pending bits and code into one working word
  assign len_eff   = sym_ok_r ? rd_r[ENTRY_W-1:CODE_W] : '0;
  assign code_left = rd_r[CODE_W-1:0] << (LEN_W'(CODE_W) - len_eff);
  assign pend_left = {1'b0, pend_r} << (4'd8 - {1'b0, pcnt_r});
  assign tail_byte = work_r[WORK_W-1:CODE_W] >> (4'd8 - cnt_r[3:0]);

  // accumulator next values
  always_comb begin
    work_nxt = work_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    if (cmd.combine) begin
      work_nxt = {pend_left, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> pcnt_r);
      cnt_nxt  = CNT_W'(pcnt_r) + len_eff;
    end
    if (cmd.emit_full) begin
      work_nxt = work_r << BYTE_W;
      cnt_nxt  = cnt_r - CNT_W'(BYTE_W);
    end
    if (cmd.flush) begin
      cnt_nxt  = '0;
      pend_nxt = '0;
      pcnt_nxt = '0;
    end
    if (cmd.store_pend) begin
      pend_nxt = tail_byte[PEND_W-1:0];
      pcnt_nxt = cnt_r[PCNT_W-1:0];
    end
  end

  // pending bits are architectural state and reset to empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    cnt_r  <= cnt_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_full || cmd.flush) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_full || cmd.flush) begin
      out_byte_r       <= work_r[WORK_W-1:CODE_W];
      out_run_end_r    <= cmd.run_end;
      out_stream_end_r <= cmd.stream_end;
    end
  end

  // status to the controller
  assign sts.cnt_ge8  = cnt_r >= CNT_W'(8);
  assign sts.cnt_eq8  = cnt_r == CNT_W'(8);
  assign sts.cnt_lt16 = cnt_r < CNT_W'(16);
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.fin      = fin_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_end    = out_run_end_r;
  assign out_stream_end = out_stream_end_r;

endmodule

`default_nettype wire

// ----- rtl/huffman_code_bit_packer.sv -----
// huffman_code_bit_packer: top level, joins controller and datapath
// depends on hcbp_pkg, hcbp_ctrl and hcbp_datapath
//
// Huffman code bit packer. A load request (action 0) writes a symbol's code
// word and length into the code table; lengths are clamped to MAX_CODE_LEN
// and to 32. An encode request (action 1) reads the table, appends the code's
// bits MSB first to the pending partial byte and sends every full byte out;
// final_symbol flushes a partial byte padded with zeros and marks it
// stream_end. run_end flags the last byte of each request. One request is
// handled at a time: an encode is accepted and reads the table, then merges
// the code with the pending bits, then sends one byte per cycle while the
// output side keeps up, and ends with a closing step that keeps the leftover
// bits (no closing step when a flush ends it). The table needs no clearing;
// an entry must be loaded before it is encoded.
`default_nettype none

module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    in_symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   in_code_word,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    in_code_length,
  input  wire logic                          in_final_symbol,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_run_end,
  output logic                               out_stream_end
);
  import hcbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  hcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and bit accumulator
  hcbp_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .in_final_symbol (in_final_symbol),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_stream_end  (out_stream_end)
  );

endmodule

`default_nettype wire

// ----- rtl/hcbp_checker.sv -----
// hcbp_checker: port-level assertions of the huffman code bit packer
// depends on hcbp_pkg; attached to huffman_code_bit_packer by bind
`default_nettype none

module hcbp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_action,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                          out_run_end,
  input wire logic                          out_stream_end
);
  import hcbp_pkg::*;

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_run_end) && $stable(out_stream_end))
    else $error("output byte changed while stalled");

  // the end of the stream is also the end of its request
  a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_end)
    else $error("stream_end without run_end");

  // a new request is taken only after the previous one's bytes are all issued
  a_ready_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_run_end)
    else $error("ready while a request still has bytes to send");

  // a table load never produces a byte
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_LOAD && !out_valid |=> !out_valid)
    else $error("output after a table load");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_run_end    (out_run_end),
  .out_stream_end (out_stream_end)
);

`default_nettype wire

// ----- test/tb.sv -----
// tb: self-checking bench for huffman_code_bit_packer, loads code tables and encodes symbols
// depends on hcbp_pkg and huffman_code_bit_packer; predicts packed bytes and checks each one
// directed table first, then random load and encode requests with random stalls on both sides

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int RAND_ITEMS  = 105;
  localparam int TAIL_CYCLES = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int ROW_COUNT   = 25;

  typedef struct packed {
    logic              action;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic              final_symbol;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_end;
    logic              stream_end;
  } packed_byte_t;

  // directed row: request, then a typed expectation of fix_n equal bytes when fixed is set
  typedef struct packed {
    req_t              req;
    logic              fixed;
    logic [2:0]        fix_n;
    logic [BYTE_W-1:0] fix_data;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_action;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_word;
  logic [LEN_W-1:0]  in_code_length;
  logic              in_final_symbol;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_run_end;
  logic              out_stream_end;

  // predictor state: code table and the partial byte
  logic [CODE_W-1:0] code_words [256];
  logic [LEN_W-1:0]  code_lens [256];
  bit                code_loaded [256];
  logic [SYM_W-1:0]  loaded_syms [$];
  logic [BYTE_W-1:0] acc_bits;
  int                acc_count;

  packed_byte_t expected_bytes [$];
  int           mismatches;
  int           quiet_cycles;

  //   action      symbol  code_word      len     fin   fixed n     data
  row_t directed_rows [ROW_COUNT] = '{
    {ACT_LOAD,   8'h00, 32'h0000_00FF, 6'd8,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 3'd1, 8'hFF},
    {ACT_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 3'd4, 8'hFF},
    // zero length code
    {ACT_LOAD,   8'h01, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 3'd0, 8'h00},
    // final with nothing pending gives nothing
    {ACT_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 3'd0, 8'h00},
    {ACT_LOAD,   8'h02, 32'h0000_0001, 6'd1,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 3'd0, 8'h00},
    // empty code marked final still flushes the pending bit
    {ACT_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 3'd1, 8'h80},
    // overlong length saturates, final ignored on load
    {ACT_LOAD,   8'h03, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 3'd0, 8'h00},
    // final code crossing byte boundaries: five bytes
    {ACT_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 3'd0, 8'h00},
    {ACT_LOAD,   8'h10, 32'h0000_0000, 6'd32, 1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 3'd4, 8'h00},
    {ACT_LOAD,   8'h80, 32'hAAAA_AAAA, 6'd33, 1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_LOAD,   8'h7F, 32'h5555_5555, 6'd31, 1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_LOAD,   8'h04, 32'h0000_0005, 6'd3,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 3'd0, 8'h00},
    // code word bits above the length are dropped
    {ACT_LOAD,   8'h05, 32'hF0F0_F0F0, 6'd12, 1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 3'd0, 8'h00},
    {ACT_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 3'd0, 8'h00}
  };

  huffman_code_bit_packer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .in_final_symbol (in_final_symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_stream_end  (out_stream_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // table update on load, bit packing on encode; keep selects whether bytes are queued
  function automatic void pack_code(input req_t r, input bit keep);
    logic [CODE_W-1:0] code;
    int                clen;
    logic [BYTE_W-1:0] made [$];
    packed_byte_t      item;
    if (r.action == ACT_LOAD) begin
      if (!code_loaded[r.symbol]) loaded_syms.push_back(r.symbol);
      code_loaded[r.symbol] = 1'b1;
      code_words[r.symbol] = r.code_word;
      code_lens[r.symbol] = (r.code_length > CODE_W) ? LEN_W'(CODE_W) : r.code_length;
      return;
    end
    code = code_words[r.symbol];
    clen = code_lens[r.symbol];
    // shift in msb first, emit every full byte
    for (int i = clen - 1; i >= 0; i--) begin
      acc_bits = {acc_bits[BYTE_W-2:0], code[i]};
      acc_count++;
      if (acc_count == BYTE_W) begin
        made.push_back(acc_bits);
        acc_bits = '0;
        acc_count = 0;
      end
    end
    // zero padded flush on the last symbol
    if (r.final_symbol && acc_count != 0) begin
      made.push_back(acc_bits << (BYTE_W - acc_count));
      acc_bits = '0;
      acc_count = 0;
    end
    if (keep) begin
      foreach (made[k]) begin
        item.data = made[k];
        item.run_end = (k == made.size() - 1);
        item.stream_end = item.run_end & r.final_symbol;
        expected_bytes.push_back(item);
      end
    end
  endfunction

  // present one request after a gap and hold it until accepted
  task automatic send_request(input req_t r, input int gap, input bit keep);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= r.action;
    in_symbol       <= r.symbol;
    in_code_word    <= r.code_word;
    in_code_length  <= r.code_length;
    in_final_symbol <= r.final_symbol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pack_code(r, keep);
  endtask

  // stop sending and wait until every expected byte has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    req_t         r;
    int           gap;
    packed_byte_t item;
    in_valid        = 1'b0;
    in_action       = ACT_LOAD;
    in_symbol       = '0;
    in_code_word    = '0;
    in_code_length  = '0;
    in_final_symbol = 1'b0;
    rst_n           = 1'b0;
    acc_bits        = '0;
    acc_count       = 0;
    mismatches      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, $urandom_range(0, 4), !directed_rows[k].fixed);
      if (directed_rows[k].fixed) begin
        for (int j = 0; j < directed_rows[k].fix_n; j++) begin
          item.data = directed_rows[k].fix_data;
          item.run_end = (j == directed_rows[k].fix_n - 1);
          item.stream_end = item.run_end & directed_rows[k].req.final_symbol;
          expected_bytes.push_back(item);
        end
      end
    end
    wait_drained();

    // random loads and encodes of loaded symbols, back to back every third stretch
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 2) wait_drained();
      gap = ((k / 24) % 3 == 1) ? 0 : $urandom_range(0, 4);
      r.code_word = $urandom;
      r.final_symbol = ($urandom_range(0, 5) == 0);
      if (loaded_syms.size() == 0 || $urandom_range(0, 4) == 0) begin
        r.action = ACT_LOAD;
        r.symbol = SYM_W'($urandom_range(0, 255));
        r.code_length = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 63))
                                                    : LEN_W'($urandom_range(1, 12));
      end else begin
        r.action = ACT_ENCODE;
        r.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        r.code_length = LEN_W'($urandom_range(0, 63));
      end
      send_request(r, gap, 1'b1);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // byte sink with random stalls, checks each accepted byte
  initial begin : receiver
    int           stall;
    int           taken;
    packed_byte_t got;
    packed_byte_t want;
    out_ready = 1'b0;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = ((taken / 20) % 3 == 1) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      got = {out_byte, out_run_end, out_stream_end};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %h run_end %b stream_end %b",
                   got.data, got.run_end, got.stream_end);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.run_end !== want.run_end ||
            got.stream_end !== want.stream_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %h/%b/%b got %h/%b/%b (byte/run_end/stream_end)",
                     want.data, want.run_end, want.stream_end,
                     got.data, got.run_end, got.stream_end);
        end
      end
    end
  end

  // watchdog on cycles with no request or byte moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/hcbp_pkg.sv
rtl/hcbp_ctrl.sv
rtl/hcbp_datapath.sv
rtl/huffman_code_bit_packer.sv
rtl/hcbp_checker.sv
test/tb.sv
